### design/sparse_bucket_group_store_core_assert.svh
// Assertion macros used by the sparse bucket store datapath.
`ifndef SPARSE_BUCKET_GROUP_STORE_CORE_ASSERT_SVH
`define SPARSE_BUCKET_GROUP_STORE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Check that cond holds whenever trig holds, in the same cycle.
`define SBGS_ASSERT_NOW(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error(msg);
// Check that cond holds in the cycle after trig.
`define SBGS_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);
`else
`define SBGS_ASSERT_NOW(lbl, trig, cond, msg)
`define SBGS_ASSERT_NEXT(lbl, trig, cond, msg)
`endif
`endif

### design/sbgs_pkg.sv
// Shared types and constants of the sparse bucket group store.
package sbgs_pkg;

    localparam int BUCKETS     = 32;
    localparam int BUCKET_W    = 5;
    localparam int VALUE_W     = 32;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND_END,
        S_FIND_START,
        S_SHIFT,
        S_PLACE,
        S_QUERY,
        S_REPLY
    } t_state;

    typedef enum logic [1:0] {
        REP_OK,
        REP_DROP,
        REP_EMPTY
    } t_reply;

    typedef struct packed {
        logic   capture;
        logic   find_end;
        logic   find_start;
        logic   shift;
        logic   place;
        logic   query;
        logic   reply;
        t_reply reply_code;
    } t_cmd;

    typedef struct packed {
        logic is_query;
        logic full;
        logic occupied;
        logic shift_done;
        logic query_done;
        logic out_free;
    } t_status;

endpackage

### design/sbgs_ctrl.sv
// Controller state machine of the sparse bucket group store.
module sbgs_ctrl
    import sbgs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    t_reply r_reply, n_reply;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_reply <= REP_OK;
        end else begin
            r_state <= n_state;
            r_reply <= n_reply;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_reply    = r_reply;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.reply_code = r_reply;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_FIND_END;
                end
            end
            S_FIND_END: begin
                o_cmd.find_end = 1'b1;
                if (i_status.is_query) begin
                    if (!i_status.occupied) begin
                        n_reply = REP_EMPTY;
                        n_state = S_REPLY;
                    end else begin
                        n_state = S_FIND_START;
                    end
                end else if (i_status.full) begin
                    n_reply = REP_DROP;
                    n_state = S_REPLY;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_FIND_START: begin
                o_cmd.find_start = 1'b1;
                n_state          = S_QUERY;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_status.shift_done) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_reply     = REP_OK;
                n_state     = S_REPLY;
            end
            S_QUERY: begin
                o_cmd.query = 1'b1;
                if (i_status.query_done) begin
                    n_state = S_IDLE;
                end
            end
            S_REPLY: begin
                if (i_status.out_free) begin
                    o_cmd.reply = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### design/sbgs_dpath.sv
// Datapath of the sparse bucket group store: bitmap, offsets, item memory, output register.
module sbgs_dpath
    import sbgs_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    input  logic                   i_kind,
    input  logic [BUCKET_W-1:0]    i_bucket,
    input  logic [VALUE_W-1:0]     i_value,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [VALUE_W-1:0]     o_out_item,
    output logic                   o_out_last,
    output logic                   o_out_empty,
    output logic                   o_out_dropped
);

`include "sparse_bucket_group_store_core_assert.svh"

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic                r_kind;
    logic [BUCKET_W-1:0] r_bucket;
    logic [VALUE_W-1:0]  r_value;
    logic [BUCKETS-1:0]  r_occ;
    logic [CW-1:0]       r_start [BUCKETS];
    logic [CW-1:0]       r_total;
    logic [CW-1:0]       r_end;
    logic [CW-1:0]       r_ptr;
    logic [AW-1:0]       r_wa;
    logic                r_wv;
    logic [VALUE_W-1:0]  r_rd_data;
    logic                r_rd_pend;
    logic                r_rd_last;
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_item;
    logic                r_out_last;
    logic                r_out_empty;
    logic                r_out_dropped;

    logic [VALUE_W-1:0]  mem [CAPACITY];

    logic [CW-1:0]       end_sel;
    logic [CW-1:0]       first_sel;
    logic [CW-1:0]       ptr_dec;
    logic [CW-1:0]       ptr_inc;
    logic                out_free;
    logic                sh_rd;
    logic                q_load;
    logic                q_issue;
    logic                mem_re;
    logic [AW-1:0]       mem_ra;
    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    logic [VALUE_W-1:0]  mem_wd;

    // End of a bucket is the start of the next bucket, or the fill level for the top one.
    assign end_sel   = (r_bucket == BUCKET_W'(BUCKETS - 1)) ? r_total
                                                            : r_start[r_bucket + BUCKET_W'(1)];
    assign first_sel = r_start[r_bucket];
    assign ptr_dec   = r_ptr - CW'(1);
    assign ptr_inc   = r_ptr + CW'(1);
    assign out_free  = !r_out_valid || i_out_ready;

    assign sh_rd   = i_cmd.shift && (r_ptr > r_end);
    assign q_load  = i_cmd.query && r_rd_pend && out_free;
    assign q_issue = i_cmd.query && (r_ptr < r_end) && (!r_rd_pend || q_load);

    assign mem_re = sh_rd || q_issue;
    assign mem_ra = sh_rd ? ptr_dec[AW-1:0] : r_ptr[AW-1:0];
    assign mem_we = (i_cmd.shift && r_wv) || i_cmd.place;
    assign mem_wa = i_cmd.place ? r_end[AW-1:0] : r_wa;
    assign mem_wd = i_cmd.place ? r_value : r_rd_data;

    assign o_status.is_query   = (r_kind == KIND_QUERY);
    assign o_status.full       = (r_total >= CW'(CAPACITY));
    assign o_status.occupied   = r_occ[r_bucket];
    assign o_status.shift_done = !(r_ptr > r_end) && !r_wv;
    assign o_status.query_done = !(r_ptr < r_end) && !r_rd_pend;
    assign o_status.out_free   = out_free;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    // Captured transaction fields and cursors.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= i_kind;
            r_bucket <= i_bucket;
            r_value  <= i_value;
        end
        if (i_cmd.find_end) begin
            r_end <= end_sel;
            r_ptr <= r_total;
        end else if (i_cmd.find_start) begin
            r_ptr <= first_sel;
        end else if (sh_rd) begin
            r_ptr <= ptr_dec;
        end else if (q_issue) begin
            r_ptr <= ptr_inc;
        end
        if (sh_rd) begin
            r_wa <= r_ptr[AW-1:0];
        end
        if (q_issue) begin
            r_rd_last <= (ptr_inc == r_end);
        end
    end

    // Bitmap, offsets and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= '0;
            r_total <= '0;
            for (int j = 0; j < BUCKETS; j++) begin
                r_start[j] <= '0;
            end
        end else if (i_cmd.place) begin
            r_occ[r_bucket] <= 1'b1;
            r_total         <= r_total + CW'(1);
            for (int j = 1; j < BUCKETS; j++) begin
                if (BUCKET_W'(j) > r_bucket) begin
                    r_start[j] <= r_start[j] + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv      <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            r_wv <= sh_rd;
            if (q_issue) begin
                r_rd_pend <= 1'b1;
            end else if (q_load) begin
                r_rd_pend <= 1'b0;
            end
        end
    end

    // Output register: query data or a single status result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (q_load || i_cmd.reply) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_load) begin
            r_out_item    <= r_rd_data;
            r_out_last    <= r_rd_last;
            r_out_empty   <= 1'b0;
            r_out_dropped <= 1'b0;
        end else if (i_cmd.reply) begin
            r_out_item    <= '0;
            r_out_last    <= 1'b1;
            r_out_empty   <= (i_cmd.reply_code == REP_EMPTY);
            r_out_dropped <= (i_cmd.reply_code == REP_DROP);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_item    = r_out_item;
    assign o_out_last    = r_out_last;
    assign o_out_empty   = r_out_empty;
    assign o_out_dropped = r_out_dropped;

    `SBGS_ASSERT_NOW(a_total_cap, 1'b1, r_total <= CW'(CAPACITY), "fill level above capacity")
    `SBGS_ASSERT_NOW(a_top_start, 1'b1, r_start[BUCKETS-1] <= r_total, "offset beyond fill level")
    `SBGS_ASSERT_NOW(a_shift_addr, i_cmd.shift && r_wv, CW'(r_wa) > r_end,
        "shift write at or below bucket end")

endmodule

### design/sparse_bucket_group_store_core.sv
// Top level of the sparse bucket group store: stream ports, controller and datapath.
//
// Channel   Direction  Handshake       Payload
// s_axis    in         tvalid/tready   tuser: kind; tdata: bucket, value
// m_axis    out        tvalid/tready   tdata: item; tlast: last; tuser: bucket_empty, dropped
//
// A transaction is taken only while the controller is idle; one is in work at a time.
// Insert: look up the bucket end, then shift the N items stored above it (N < CAPACITY)
//   up by one in the item memory, one item per cycle, place the value and reply; a
//   refused insert goes from the lookup straight to the reply. The controller then
//   returns to idle for the next transaction.
// Query: look up the bucket start, then one result per cycle out of the item memory read
//   port while m_axis takes them; an absent bucket gives a single status result.
// No clearing pass after reset: offsets and the bitmap are cleared directly by the reset.
// A stalled m_axis holds the output register and pauses query reads of the item memory;
//   the next s_axis transaction may be taken while the last result still waits.
module sparse_bucket_group_store_core
    import sbgs_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // [4:0] bucket, [36:5] value, rest zero
    input  logic                   i_s_axis_tuser,   // [0] kind (0 insert, 1 query)
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // [31:0] item
    output logic [OUT_TUSER_W-1:0] o_m_axis_tuser,   // [0] bucket_empty, [1] dropped
    output logic                   o_m_axis_tlast
);

    t_cmd    cmd;
    t_status status;
    logic    out_empty;
    logic    out_dropped;

    // Controller: sequences lookup, shift, placement, readout and reply.
    sbgs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath, fed with the kind, bucket and value unpacked from the stream transaction.
    sbgs_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_kind        (i_s_axis_tuser),
        .i_bucket      (i_s_axis_tdata[BUCKET_W-1:0]),
        .i_value       (i_s_axis_tdata[BUCKET_W+VALUE_W-1:BUCKET_W]),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_out_item    (o_m_axis_tdata),
        .o_out_last    (o_m_axis_tlast),
        .o_out_empty   (out_empty),
        .o_out_dropped (out_dropped)
    );

    assign o_m_axis_tuser = {out_dropped, out_empty};

endmodule
